// ===== design/dpsc_pkg.sv =====
// Package for the decimated PI phase-shift controller.
// Holds widths, fixed constants, register indexes and the control summary type.
// No dependencies.
`timescale 1ns / 1ps

package dpsc_pkg;

  // Field widths
  localparam int RAW_W    = 16;
  localparam int MEAS_W   = 17;
  localparam int ERR_W    = 18;
  localparam int TGT_W    = 13;
  localparam int GAIN_W   = 10;
  localparam int SHIFT_W  = 10;
  localparam int TICK_W   = 16;
  localparam int INTEG_W  = 32;
  localparam int PROP_W   = GAIN_W + 1 + ERR_W;    // kp * err, signed
  localparam int IPROD_W  = GAIN_W + 1 + INTEG_W;  // ki * acc, signed
  localparam int CTRL_W   = IPROD_W;               // sum fits, |sum| < 2^42
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Fixed constants
  localparam logic [MEAS_W-1:0]  SENSOR_OFFSET = 17'd4;
  localparam int                 SHIFT_DIVISOR = 80;
  localparam logic [SHIFT_W-1:0] SHIFT_FLOOR   = 10'd5;

  // Control values at or above this give a shift beyond any limit
  localparam int BIG_THRESH = SHIFT_DIVISOR * (1 << SHIFT_W);
  localparam int LOW_W      = 17;                   // covers values below BIG_THRESH
  // c/80 = (c>>4)/5; divide by 5 via reciprocal multiply
  localparam int PRE_SHIFT  = 4;
  localparam int QIN_W      = LOW_W - PRE_SHIFT;    // 13 bits
  localparam logic [15:0] RECIP_5   = 16'd52429;    // ceil(2^18 / 5)
  localparam int          RECIP_SH  = 18;
  localparam int          QPROD_W   = QIN_W + 16;

  // Reset values of the configuration registers
  localparam logic [TGT_W-1:0]   TARGET_RST   = 13'd280;
  localparam logic [GAIN_W-1:0]  PROP_RST     = 10'd10;
  localparam logic [GAIN_W-1:0]  INTEG_RST    = 10'd5;
  localparam logic [SHIFT_W-1:0] LIMIT_RST    = 10'd350;
  localparam logic [TICK_W-1:0]  INTERVAL_RST = 16'd7000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd4;

  // Summary of the control value handed to the shift quantizer
  typedef struct packed {
    logic             neg;   // control value below zero
    logic             big;   // control value at or above BIG_THRESH
    logic [LOW_W-1:0] low;   // control value when neither flag is set
  } ctl_sum_t;

endpackage

// ===== design/dpsc_shift_quant.sv =====
// Phase shift quantizer: control summary / 80, clamp to limit, non-positive quotient becomes five.
// Depends on dpsc_pkg.
`timescale 1ns / 1ps

module dpsc_shift_quant import dpsc_pkg::*; (
  input  ctl_sum_t             ctl,
  input  logic [SHIFT_W-1:0]   limit,
  output logic [SHIFT_W-1:0]   shift
);

  logic [QIN_W-1:0]   q_in;
  logic [QPROD_W-1:0] q_prod;
  logic [SHIFT_W-1:0] quot;

  // Divide by 80: drop four bits, then multiply by the reciprocal of five
  assign q_in   = ctl.low[LOW_W-1:PRE_SHIFT];
  assign q_prod = QPROD_W'(q_in) * QPROD_W'(RECIP_5);
  assign quot   = q_prod[RECIP_SH +: SHIFT_W];

  // Clamp; a non-positive quotient becomes the floor value
  always_comb begin
    priority if (ctl.neg) begin
      shift = SHIFT_FLOOR;
    end else if (ctl.big) begin
      shift = limit;
    end else if (quot > limit) begin
      shift = limit;
    end else if (quot == '0) begin
      shift = SHIFT_FLOOR;
    end else begin
      shift = quot;
    end
  end

endmodule

// ===== design/decimated_pi_phase_shift_controller.sv =====
// Decimated PI phase-shift controller, registered pipeline of five stages.
// Stages A-D, then the output register; one request per cycle while out_stall is low.
// Loops: the integrator add/saturate in the second stage and the tick counter.
// Stages advance independently, so a bubble lets input be taken under output stall.
// Reset (rst, synchronous) empties the pipeline, clears tick count, integrator and
// held shift, and loads the configuration registers with their defaults.
`timescale 1ns / 1ps

module decimated_pi_phase_shift_controller import dpsc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [RAW_W-1:0]      raw_voltage,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [MEAS_W-1:0]     measured_voltage,
  output logic [SHIFT_W-1:0]           phase_shift,
  output logic                         updated
);

  // Configuration registers
  logic [TGT_W-1:0]   target_voltage;
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integral_gain;
  logic [SHIFT_W-1:0] shift_limit;
  logic [TICK_W-1:0]  update_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_voltage  <= TARGET_RST;
      prop_gain       <= PROP_RST;
      integral_gain   <= INTEG_RST;
      shift_limit     <= LIMIT_RST;
      update_interval <= INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TARGET:   target_voltage  <= cfg_data[TGT_W-1:0];
        CFG_PROP:     prop_gain       <= cfg_data[GAIN_W-1:0];
        CFG_INTEG:    integral_gain   <= cfg_data[GAIN_W-1:0];
        CFG_LIMIT:    shift_limit     <= cfg_data[SHIFT_W-1:0];
        CFG_INTERVAL: update_interval <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables, back to front
  logic en_a, en_b, en_c, en_d, en_out;
  logic a_valid, b_valid, c_valid, d_valid;

  assign en_out   = !out_valid || !out_stall;
  assign en_d     = !d_valid || en_out;
  assign en_c     = !c_valid || en_d;
  assign en_b     = !b_valid || en_c;
  assign en_a     = !a_valid || en_b;
  assign in_stall = !en_a;

  logic accept;
  assign accept = in_valid && en_a;

  // Decimation counter
  logic [TICK_W-1:0] tick_count;
  logic              fire;

  assign fire = (tick_count == '0) || (tick_count >= update_interval);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (accept) begin
      tick_count <= fire ? TICK_W'(1) : tick_count + TICK_W'(1);
    end
  end

  // Stage A: calibrate and form the error
  logic signed [MEAS_W-1:0] meas_in;
  logic signed [ERR_W-1:0]  err_in;
  logic                     a_fire;
  logic signed [MEAS_W-1:0] a_meas;
  logic signed [ERR_W-1:0]  a_err;

  assign meas_in = MEAS_W'(raw_voltage) - $signed(SENSOR_OFFSET);
  assign err_in  = $signed(ERR_W'(target_voltage)) - ERR_W'(meas_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_fire <= fire;
      a_meas <= meas_in;
      a_err  <= err_in;
    end
  end

  // Stage B: saturating integrator
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [INTEG_W:0]   acc_wide;
  logic signed [INTEG_W-1:0] acc_sat;
  logic                      b_fire;
  logic signed [MEAS_W-1:0]  b_meas;
  logic signed [ERR_W-1:0]   b_err;
  logic signed [INTEG_W-1:0] b_acc;

  assign acc_wide = (INTEG_W+1)'(integral_sum) + (INTEG_W+1)'(a_err);

  always_comb begin
    if (acc_wide[INTEG_W] != acc_wide[INTEG_W-1]) begin
      acc_sat = acc_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                  : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      b_valid      <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
      if (a_valid && a_fire) begin
        integral_sum <= acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_fire <= a_fire;
      b_meas <= a_meas;
      b_err  <= a_err;
      b_acc  <= acc_sat;
    end
  end

  // Stage C: gain products
  logic                      c_fire;
  logic signed [MEAS_W-1:0]  c_meas;
  logic signed [PROP_W-1:0]  c_prop;
  logic signed [IPROD_W-1:0] c_integ;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_fire  <= b_fire;
      c_meas  <= b_meas;
      c_prop  <= PROP_W'($signed({1'b0, prop_gain})) * PROP_W'(b_err);
      c_integ <= IPROD_W'($signed({1'b0, integral_gain})) * IPROD_W'(b_acc);
    end
  end

  // Stage D: sum and summarize the control value
  logic signed [CTRL_W-1:0] ctrl_sum;
  logic                     d_fire;
  logic signed [MEAS_W-1:0] d_meas;
  ctl_sum_t                 d_ctl;

  assign ctrl_sum = CTRL_W'(c_prop) + c_integ;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en_d) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_fire    <= c_fire;
      d_meas    <= c_meas;
      d_ctl.neg <= ctrl_sum[CTRL_W-1];
      d_ctl.big <= (ctrl_sum >= $signed(CTRL_W'(BIG_THRESH)));
      d_ctl.low <= ctrl_sum[LOW_W-1:0];
    end
  end

  // Stage E: quantize, clamp, hold
  logic [SHIFT_W-1:0] new_shift;

  dpsc_shift_quant u_quant (
    .ctl   (d_ctl),
    .limit (shift_limit),
    .shift (new_shift)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      phase_shift <= '0;
    end else if (en_out) begin
      out_valid <= d_valid;
      if (d_valid && d_fire) begin
        phase_shift <= new_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && d_valid) begin
      measured_voltage <= d_meas;
      updated          <= d_fire;
    end
  end

endmodule

// ===== design/dpsc_checker.sv =====
// Port-level checks for the decimated PI phase-shift controller, bound to the top level.
// Depends on dpsc_pkg.
`timescale 1ns / 1ps

module dpsc_checker import dpsc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [MEAS_W-1:0] measured_voltage,
  input logic [SHIFT_W-1:0]       phase_shift,
  input logic                     updated
);

  // A held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(measured_voltage)
      && $stable(phase_shift) && $stable(updated))
    else $error("result changed while stalled");

  // With no result pending the pipeline cannot be backed up
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // The held shift only moves with a request that ran an update
  a_shift_moves_on_update: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(phase_shift) |-> out_valid && updated)
    else $error("phase shift changed without an update");

  // After reset no result is shown
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind decimated_pi_phase_shift_controller dpsc_checker u_dpsc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .measured_voltage (measured_voltage),
  .phase_shift      (phase_shift),
  .updated          (updated)
);

// ===== dv/tb_decimated_pi_phase_shift_controller.sv =====
// Self-checking testbench for the decimated PI phase-shift controller.
// Runs a directed table, then random phases and an integrator soak, checked against an in-bench
// PI model or, for known table rows, fixed expected values. Depends on dpsc_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_decimated_pi_phase_shift_controller;
  import dpsc_pkg::*;

  localparam int     TIMEOUT_NS  = 40_000_000;
  localparam int     NUM_PHASES  = 8;
  localparam int     PHASE_ITEMS = 70;
  localparam int     SAT_EXTRA   = 40;
  localparam int     HOLD_CYCLES = 64;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     MAX_SHOWN   = 10;
  localparam longint INTEG_MAX   = 64'sd2147483647;
  localparam longint INTEG_MIN   = -64'sd2147483648;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE1 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 3'd7;

  typedef struct {
    logic signed [MEAS_W-1:0] meas;
    logic [SHIFT_W-1:0]       shift;
    logic                     upd;
  } tick_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         data;
    logic signed [RAW_W-1:0]  raw;
    tick_result_t             known;
  } plan_row_t;

  // DUT signals, all driven from time zero
  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]            cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [RAW_W-1:0]     raw_voltage = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [MEAS_W-1:0]    measured_voltage;
  logic [SHIFT_W-1:0]          phase_shift;
  logic                        updated;

  decimated_pi_phase_shift_controller u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .raw_voltage      (raw_voltage),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .measured_voltage (measured_voltage),
    .phase_shift      (phase_shift),
    .updated          (updated)
  );

  // Controller model: configuration mirror and state
  logic [TGT_W-1:0]   m_target   = TARGET_RST;
  logic [GAIN_W-1:0]  m_kp       = PROP_RST;
  logic [GAIN_W-1:0]  m_ki       = INTEG_RST;
  logic [SHIFT_W-1:0] m_limit    = LIMIT_RST;
  logic [TICK_W-1:0]  m_interval = INTERVAL_RST;
  logic [TICK_W-1:0]  m_ticks    = '0;
  longint             m_integ    = 0;
  logic [SHIFT_W-1:0] m_shift    = '0;

  tick_result_t pending_ticks[$];
  tick_result_t want;
  tick_result_t blank_res = '{default: '0};
  plan_row_t    plan[$];

  // Bookkeeping
  int  mismatches = 0;
  int  results_seen = 0;
  int  updates_seen = 0;
  int  items_sent = 0;
  int  limit_hits = 0;
  int  floor_hits = 0;
  int  sat_hi = 0;
  int  sat_lo = 0;
  bit  tx_calm = 1'b0;

  // Receiver control
  int  hold_asked = 0;
  int  holds_done = 0;
  int  stall_left = 0;
  int  rx_stretch = 0;
  bit  rx_busy = 1'b0;
  bit  rx_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // One PWM tick through the controller model
  function automatic tick_result_t pi_tick(input logic signed [RAW_W-1:0] raw);
    tick_result_t r;
    longint       meas;
    longint       err;
    longint       acc;
    longint       ctl;
    longint       q;
    bit           fire;
    meas = longint'(raw) - longint'(SENSOR_OFFSET);
    fire = (m_ticks == '0) || (m_ticks >= m_interval);
    if (fire) begin
      err = longint'(m_target) - meas;
      acc = m_integ + err;
      if (acc > INTEG_MAX) begin
        acc = INTEG_MAX;
        sat_hi++;
      end else if (acc < INTEG_MIN) begin
        acc = INTEG_MIN;
        sat_lo++;
      end
      m_integ = acc;
      ctl = longint'(m_kp) * err + longint'(m_ki) * acc;
      q = ctl / SHIFT_DIVISOR;   // truncates toward zero
      if (q > longint'(m_limit)) begin
        m_shift = m_limit;
        limit_hits++;
      end else if (q <= 0) begin
        m_shift = SHIFT_FLOOR;
        floor_hits++;
      end else begin
        m_shift = q[SHIFT_W-1:0];
      end
      m_ticks = TICK_W'(1);
    end else begin
      m_ticks = m_ticks + 1'b1;
    end
    r.meas  = meas[MEAS_W-1:0];
    r.shift = m_shift;
    r.upd   = fire;
    return r;
  endfunction

  function automatic void plan_add(input row_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data,
                                   input logic signed [RAW_W-1:0] raw,
                                   input logic signed [MEAS_W-1:0] meas,
                                   input logic [SHIFT_W-1:0] shift, input logic upd);
    plan_row_t r;
    r.kind        = kind;
    r.idx         = idx;
    r.data        = data;
    r.raw         = raw;
    r.known.meas  = meas;
    r.known.shift = shift;
    r.known.upd   = upd;
    plan.push_back(r);
  endfunction

  // Register write: one cycle with the enable high; the caller lowers it later
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_TARGET:   m_target   = data[TGT_W-1:0];
      CFG_PROP:     m_kp       = data[GAIN_W-1:0];
      CFG_INTEG:    m_ki       = data[GAIN_W-1:0];
      CFG_LIMIT:    m_limit    = data[SHIFT_W-1:0];
      CFG_INTERVAL: m_interval = data[TICK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering requests and wait for every result to come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
  endtask

  // Offer one sample, after an optional gap, and hold it until accepted
  task automatic send_sample(input logic signed [RAW_W-1:0] raw, input bit typed,
                             input tick_result_t typed_res);
    tick_result_t predicted;
    int           gap;
    int           roll;
    predicted = pi_tick(raw);
    gap = 0;
    if (!tx_calm) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) gap = $urandom_range(6, 30);
      else if (roll >= 55) gap = $urandom_range(1, 3);
    end
    cfg_write <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    raw_voltage <= raw;
    if (typed) pending_ticks.push_back(typed_res);
    else pending_ticks.push_back(predicted);
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Receiver: random stall stretches, long stalls, and requested hold-offs
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_asked != holds_done) begin
      holds_done++;
      stall_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_stretch = $urandom_range(20, 200);
        rx_busy = ($urandom_range(0, 2) != 0);
      end
      rx_stretch--;
      if (!rx_busy) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left = $urandom_range(8, 40);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result with no request waiting: meas %0d shift %0d upd %0b",
                   measured_voltage, phase_shift, updated);
      end else begin
        want = pending_ticks.pop_front();
        results_seen++;
        if (updated) updates_seen++;
        if (measured_voltage !== want.meas || phase_shift !== want.shift ||
            updated !== want.upd) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result %0d: expected meas %0d shift %0d upd %0b, got meas %0d shift %0d upd %0b",
                     results_seen, want.meas, want.shift, want.upd,
                     measured_voltage, phase_shift, updated);
        end
      end
    end
  end

  // Stimulus
  initial begin
    plan_row_t                row;
    logic [CFG_W-1:0]         tgt;
    logic [CFG_W-1:0]         kp;
    logic [CFG_W-1:0]         ki;
    logic [CFG_W-1:0]         lim;
    logic [CFG_W-1:0]         ivl;
    logic signed [RAW_W-1:0]  raw;
    int                       roll;
    int                       tmp;
    int                       n;
    int                       spare;
    int                       directed_items;
    bit                       pressure;

    // Directed table: first tick after reset, extreme samples, extreme registers
    plan_add(ROW_KNOWN,  '0, '0, 16'sd284,    17'sd280,     10'd5,    1'b1);
    plan_add(ROW_KNOWN,  '0, '0, 16'sh7FFF,   17'sd32763,   10'd5,    1'b0);
    plan_add(ROW_KNOWN,  '0, '0, 16'sh8000,   -17'sd32772,  10'd5,    1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd0,      '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_INTERVAL, 16'd1, '0, '0, '0, 1'b0);
    plan_add(ROW_KNOWN,  '0, '0, 16'sh8000,   -17'sd32772,  10'd350,  1'b1);
    plan_add(ROW_WRITE,  CFG_LIMIT,  16'd1023, '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_PROP,   16'd1023, '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_INTEG,  16'd0,    '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_TARGET, 16'd8191, '0, '0, '0, 1'b0);
    plan_add(ROW_KNOWN,  '0, '0, 16'sh8000,   -17'sd32772,  10'd1023, 1'b1);
    // zero gains, then negative error, then full integral gain
    plan_add(ROW_WRITE,  CFG_PROP,   16'd0,    '0, '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd1000,   '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_TARGET, 16'd0,    '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_PROP,   16'd1,    '0, '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sh7FFF,   '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_INTEG,  16'd1023, '0, '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd12345,  '0, '0, 1'b0);
    // limit below the floor value
    plan_add(ROW_WRITE,  CFG_LIMIT,  16'd2,    '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_PROP,   16'd80,   '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_INTEG,  16'd0,    '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_TARGET, 16'd100,  '0, '0, '0, 1'b0);
    plan_add(ROW_KNOWN,  '0, '0, 16'sd4,      17'sd0,       10'd2,    1'b1);
    plan_add(ROW_KNOWN,  '0, '0, 16'sd204,    17'sd200,     10'd5,    1'b1);
    plan_add(ROW_KNOWN,  '0, '0, 16'sd103,    17'sd99,      10'd1,    1'b1);
    plan_add(ROW_WRITE,  CFG_PROP,   16'd79,   '0, '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd103,    '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_LIMIT,  16'd0,    '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_PROP,   16'd80,   '0, '0, '0, 1'b0);
    plan_add(ROW_KNOWN,  '0, '0, 16'sd4,      17'sd0,       10'd0,    1'b1);
    // interval of zero updates on every tick
    plan_add(ROW_WRITE,  CFG_LIMIT,  16'd350,  '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_INTERVAL, 16'd0,  '0, '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd500,    '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, -16'sd500,   '0, '0, 1'b0);
    // largest interval, then lowered below the running tick count
    plan_add(ROW_WRITE,  CFG_INTERVAL, 16'hFFFF, '0, '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd7,      '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd8,      '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd9,      '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_INTERVAL, 16'd2,  '0, '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, 16'sd10,     '0, '0, 1'b0);
    // unused indexes are ignored; oversize target data is masked
    plan_add(ROW_WRITE,  CFG_SPARE0, 16'hFFFF, '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_SPARE1, 16'h0000, '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_SPARE2, 16'hA5A5, '0, '0, '0, 1'b0);
    plan_add(ROW_WRITE,  CFG_TARGET, 16'hFFFF, '0, '0, '0, 1'b0);
    plan_add(ROW_SAMPLE, '0, '0, -16'sd1,     '0, '0, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        reg_write(row.idx, row.data);
      end else begin
        send_sample(row.raw, row.kind == ROW_KNOWN, row.known);
      end
    end
    directed_items = items_sent;

    // Random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        // Soak: push the integrator hard upward and then downward
        settle();
        rx_quiet = 1'b1;
        tx_calm  = 1'b1;
        reg_write(CFG_TARGET, 16'd8191);
        reg_write(CFG_INTEG, 16'd1);
        reg_write(CFG_INTERVAL, 16'd1);
        reg_write(CFG_LIMIT, 16'd1023);
        reg_write(CFG_PROP, CFG_W'($urandom_range(0, 1023)));
        for (n = 0; n < SAT_EXTRA; n++) begin
          tmp = int'($urandom_range(0, 2000)) - 32768;
          raw = tmp[RAW_W-1:0];
          send_sample(raw, 1'b0, blank_res);
        end
        settle();
        reg_write(CFG_TARGET, 16'd0);
        for (n = 0; n < SAT_EXTRA; n++) begin
          tmp = 32767 - int'($urandom_range(0, 2000));
          raw = tmp[RAW_W-1:0];
          send_sample(raw, 1'b0, blank_res);
        end
        rx_quiet = 1'b0;
      end

      settle();
      if (ph == 0) begin
        tgt = 16'd0; kp = 16'd0; ki = 16'd0; lim = 16'd0; ivl = 16'd0;
      end else if (ph == 1) begin
        tgt = 16'hFFFF; kp = 16'd1023; ki = 16'd1023; lim = 16'd1023; ivl = 16'd1;
      end else begin
        tgt = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 65535))
                                          : CFG_W'($urandom_range(0, 600));
        kp  = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 65535))
                                          : CFG_W'($urandom_range(0, 20));
        ki  = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 65535))
                                          : CFG_W'($urandom_range(0, 4));
        lim = ($urandom_range(0, 3) != 0) ? CFG_W'($urandom_range(0, 65535))
                                          : CFG_W'($urandom_range(0, 6));
        roll = $urandom_range(0, 9);
        if (roll < 5) ivl = CFG_W'($urandom_range(1, 4));
        else if (roll < 7) ivl = 16'd0;
        else if (roll < 9) ivl = CFG_W'($urandom_range(5, 40));
        else ivl = CFG_W'($urandom_range(0, 65535));
      end
      reg_write(CFG_TARGET, tgt);
      reg_write(CFG_PROP, kp);
      reg_write(CFG_INTEG, ki);
      reg_write(CFG_LIMIT, lim);
      reg_write(CFG_INTERVAL, ivl);
      if ($urandom_range(0, 3) == 0) begin
        spare = $urandom_range(0, 2);
        reg_write(spare == 0 ? CFG_SPARE0 : (spare == 1 ? CFG_SPARE1 : CFG_SPARE2),
                  CFG_W'($urandom_range(0, 65535)));
      end

      // Back-pressure: receiver holds off while requests keep coming
      pressure = (ph == 2) || (ph == 5);
      if (pressure) hold_asked++;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 25 == 0) tx_calm = pressure || ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          tmp = $urandom_range(0, 65535);
        end else if (roll < 80) begin
          tmp = int'(m_target) + 4 + int'($urandom_range(0, 128)) - 64;
        end else if (roll < 90) begin
          case ($urandom_range(0, 3))
            0: tmp = 32767;
            1: tmp = -32768;
            2: tmp = 0;
            default: tmp = -1;
          endcase
        end else begin
          tmp = int'($urandom_range(0, 2000)) - 1000;
        end
        raw = tmp[RAW_W-1:0];
        send_sample(raw, 1'b0, blank_res);
      end
    end

    // Drain and report
    cfg_write <= 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d samples (%0d directed), %0d PI updates, %0d clamped to limit, %0d floored",
             items_sent, directed_items, updates_seen, limit_hits, floor_hits);
    $display("Integrator pinned high %0d and low %0d times, %0d receiver hold-offs, %0d mismatches",
             sat_hi, sat_lo, holds_done, mismatches);
    if (mismatches == 0 && pending_ticks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
